// ===== rtl/rti_pkg.sv =====
package rti_pkg;

   // field and channel widths
   localparam int COORD_W    = 32;
   localparam int IN_FIELDS  = 9;
   localparam int REQ_W      = IN_FIELDS * COORD_W;
   localparam int DIST_W     = 31;
   localparam int RSP_W      = 1 + DIST_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = COORD_W;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = CSR_IDX_W'(5);

   localparam logic [COORD_W-1:0] DIR_Z_RESET = COORD_W'(65536);

   // exact intermediate widths
   localparam int EDGE_W  = COORD_W + 1;          // edge / offset, Q17.16
   localparam int CROSS_W = 2 * EDGE_W + 1;       // P and Q, scale 2^-32
   localparam int MUL_A_W = EDGE_W;
   localparam int MUL_B_W = CROSS_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DOT_W   = PROD_W + 1;           // det, u, v, t numerators
   localparam int UV_W    = DOT_W + 1;

   // pipelined multiplier: 17-bit limbs, 17x17 partial products
   localparam int LIMB_W      = 17;
   localparam int MUL_A_LIMBS = 2;
   localparam int MUL_B_LIMBS = 4;
   localparam int AM_W        = MUL_A_LIMBS * LIMB_W;   // = MUL_A_W + 1
   localparam int BM_W        = MUL_B_LIMBS * LIMB_W;   // = MUL_B_W + 1
   localparam int PP_W        = 2 * LIMB_W;
   localparam int PQ_W        = 3 * LIMB_W;
   localparam int PH_W        = 4 * LIMB_W;
   localparam int MUL_LAT     = 6;

   // epsilon product: |det| * EPS in 26x29 pieces
   localparam int EPS_W        = 29;
   localparam logic [EPS_W-1:0] EPS_Q48 = EPS_W'(281474977);
   localparam int ADET_LIMB_W  = 26;
   localparam int ADET_LIMBS   = 4;
   localparam int ADET_X_W     = ADET_LIMBS * ADET_LIMB_W;
   localparam int EPS_PP_W     = ADET_LIMB_W + EPS_W;
   localparam int EPS_HALF_W   = 2 * ADET_LIMB_W + EPS_W;
   localparam int RHS_W        = 4 * ADET_LIMB_W + EPS_W;
   localparam int T_SHIFT      = 48;
   localparam int CMP_W        = DOT_W - 1 + T_SHIFT;
   localparam int NUM_SHIFT    = 16;
   localparam int REM_W        = DOT_W + DIST_W;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // pipeline depths
   localparam int GEOM_LAT  = 2 * MUL_LAT + 4;
   localparam int TEST_LAT  = 5;
   localparam int DIV_STEPS = DIST_W;
   localparam int UNIT_LAT  = GEOM_LAT + TEST_LAT + DIV_STEPS + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [DOT_W-1:0]   dot_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      vec_type a;
      vec_type b;
      vec_type c;
   } tri_type;

   typedef struct packed {
      vec_type origin;
      vec_type dir;
   } ray_type;

   typedef struct packed {
      edge_type x;
      edge_type y;
      edge_type z;
   } evec_type;

   typedef struct packed {
      evec_type e1;
      evec_type e2;
      evec_type t;
   } edges_type;

   typedef struct packed {
      cross_type x;
      cross_type y;
      cross_type z;
   } cvec_type;

   typedef struct packed {
      logic    valid;
      dot_type det;
      dot_type unum;
      dot_type vnum;
      dot_type tnum;
   } geom_out_type;

   typedef struct packed {
      logic             valid;
      logic             hit;
      logic             sat;
      logic [DOT_W-1:0] adet;
      logic [REM_W-1:0] num;
   } test_out_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic              sat;
      logic [DOT_W-1:0]  adet;
      logic [REM_W-1:0]  rem;
      logic [DIST_W-1:0] quo;
   } div_stage_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              hit;
   } res_type;

   typedef struct packed {
      logic    valid;
      res_type res;
   } div_out_type;

   function automatic edge_type sub_ext(coord_type p, coord_type q);
      return EDGE_W'(p) - EDGE_W'(q);
   endfunction

endpackage

// ===== rtl/rti_mul.sv =====
module rti_mul (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [rti_pkg::MUL_A_W-1:0] a,
   input  logic signed [rti_pkg::MUL_B_W-1:0] b,
   output logic signed [rti_pkg::PROD_W-1:0]  p
);
   import rti_pkg::*;

   // sign-magnitude: abs, limb products, two merge levels, final add, sign
   logic [MUL_LAT-2:0] sgn_ff;
   logic               sgn_in;
   logic [AM_W-1:0]    amag_ff, amag_in;
   logic [BM_W-1:0]    bmag_ff, bmag_in;
   logic [PP_W-1:0]    pp_ff [MUL_A_LIMBS][MUL_B_LIMBS];
   logic [PP_W-1:0]    pp_in [MUL_A_LIMBS][MUL_B_LIMBS];
   logic [PQ_W-1:0]    q_ff [MUL_B_LIMBS];
   logic [PQ_W-1:0]    q_in [MUL_B_LIMBS];
   logic [PH_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [PROD_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0]  p_ff, p_in;

   assign sgn_in  = a[MUL_A_W-1] ^ b[MUL_B_W-1];
   assign amag_in = {1'b0, (a[MUL_A_W-1] ? -a : a)};
   assign bmag_in = {1'b0, (b[MUL_B_W-1] ? -b : b)};

   always_comb begin
      for (int i = 0; i < MUL_A_LIMBS; i++) begin
         for (int j = 0; j < MUL_B_LIMBS; j++) begin
            pp_in[i][j] = PP_W'(amag_ff[i*LIMB_W +: LIMB_W]) *
                          PP_W'(bmag_ff[j*LIMB_W +: LIMB_W]);
         end
      end
      for (int j = 0; j < MUL_B_LIMBS; j++) begin
         q_in[j] = PQ_W'(pp_ff[0][j]) + (PQ_W'(pp_ff[1][j]) << LIMB_W);
      end
   end

   assign lo_in  = PH_W'(q_ff[0]) + (PH_W'(q_ff[1]) << LIMB_W);
   assign hi_in  = PH_W'(q_ff[2]) + (PH_W'(q_ff[3]) << LIMB_W);
   assign mag_in = PROD_W'(lo_ff) + (PROD_W'(hi_ff) << (2 * LIMB_W));
   assign p_in   = sgn_ff[MUL_LAT-2] ? -mag_ff : mag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sgn_ff  <= {sgn_ff[MUL_LAT-3:0], sgn_in};
         amag_ff <= amag_in;
         bmag_ff <= bmag_in;
         pp_ff   <= pp_in;
         q_ff    <= q_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         mag_ff  <= mag_in;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/rti_geom.sv =====
module rti_geom (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rti_pkg::tri_type      triangle,
   input  rti_pkg::ray_type      ray,
   output rti_pkg::geom_out_type res
);
   import rti_pkg::*;

   localparam int NMUL = 12;
   localparam int EDLY = MUL_LAT + 2;

   logic [GEOM_LAT-1:0] v_ff;
   edges_type           edges_in;
   edges_type           edges_ff [EDLY];
   edge_type            dx, dy, dz;

   edge_type                   m1_a [NMUL];
   logic signed [MUL_B_W-1:0]  m1_b [NMUL];
   logic signed [PROD_W-1:0]   m1_p [NMUL];
   edge_type                   m2_a [NMUL];
   logic signed [MUL_B_W-1:0]  m2_b [NMUL];
   logic signed [PROD_W-1:0]   m2_p [NMUL];

   cvec_type p_ff, p_in, q_ff, q_in;
   dot_type  part_ff [4];
   dot_type  part_in [4];
   logic signed [PROD_W-1:0] rest_ff [4];
   dot_type  sum_ff [4];
   dot_type  sum_in [4];
   edges_type e1s, e2s;

   assign dx = EDGE_W'(ray.dir.x);
   assign dy = EDGE_W'(ray.dir.y);
   assign dz = EDGE_W'(ray.dir.z);

   always_comb begin
      edges_in.e1.x = sub_ext(triangle.b.x, triangle.a.x);
      edges_in.e1.y = sub_ext(triangle.b.y, triangle.a.y);
      edges_in.e1.z = sub_ext(triangle.b.z, triangle.a.z);
      edges_in.e2.x = sub_ext(triangle.c.x, triangle.a.x);
      edges_in.e2.y = sub_ext(triangle.c.y, triangle.a.y);
      edges_in.e2.z = sub_ext(triangle.c.z, triangle.a.z);
      edges_in.t.x  = sub_ext(ray.origin.x, triangle.a.x);
      edges_in.t.y  = sub_ext(ray.origin.y, triangle.a.y);
      edges_in.t.z  = sub_ext(ray.origin.z, triangle.a.z);
   end

   // P = dir x E2, Q = T x E1
   assign e1s = edges_ff[0];
   always_comb begin
      m1_a[0]  = dy;       m1_b[0]  = MUL_B_W'(e1s.e2.z);
      m1_a[1]  = dz;       m1_b[1]  = MUL_B_W'(e1s.e2.y);
      m1_a[2]  = dz;       m1_b[2]  = MUL_B_W'(e1s.e2.x);
      m1_a[3]  = dx;       m1_b[3]  = MUL_B_W'(e1s.e2.z);
      m1_a[4]  = dx;       m1_b[4]  = MUL_B_W'(e1s.e2.y);
      m1_a[5]  = dy;       m1_b[5]  = MUL_B_W'(e1s.e2.x);
      m1_a[6]  = e1s.t.y;  m1_b[6]  = MUL_B_W'(e1s.e1.z);
      m1_a[7]  = e1s.t.z;  m1_b[7]  = MUL_B_W'(e1s.e1.y);
      m1_a[8]  = e1s.t.z;  m1_b[8]  = MUL_B_W'(e1s.e1.x);
      m1_a[9]  = e1s.t.x;  m1_b[9]  = MUL_B_W'(e1s.e1.z);
      m1_a[10] = e1s.t.x;  m1_b[10] = MUL_B_W'(e1s.e1.y);
      m1_a[11] = e1s.t.y;  m1_b[11] = MUL_B_W'(e1s.e1.x);
   end

   always_comb begin
      p_in.x = m1_p[0][CROSS_W-1:0]  - m1_p[1][CROSS_W-1:0];
      p_in.y = m1_p[2][CROSS_W-1:0]  - m1_p[3][CROSS_W-1:0];
      p_in.z = m1_p[4][CROSS_W-1:0]  - m1_p[5][CROSS_W-1:0];
      q_in.x = m1_p[6][CROSS_W-1:0]  - m1_p[7][CROSS_W-1:0];
      q_in.y = m1_p[8][CROSS_W-1:0]  - m1_p[9][CROSS_W-1:0];
      q_in.z = m1_p[10][CROSS_W-1:0] - m1_p[11][CROSS_W-1:0];
   end

   // det = E1.P, u = T.P, v = dir.Q, t = E2.Q
   assign e2s = edges_ff[EDLY-1];
   always_comb begin
      m2_a[0]  = e2s.e1.x; m2_b[0]  = p_ff.x;
      m2_a[1]  = e2s.e1.y; m2_b[1]  = p_ff.y;
      m2_a[2]  = e2s.e1.z; m2_b[2]  = p_ff.z;
      m2_a[3]  = e2s.t.x;  m2_b[3]  = p_ff.x;
      m2_a[4]  = e2s.t.y;  m2_b[4]  = p_ff.y;
      m2_a[5]  = e2s.t.z;  m2_b[5]  = p_ff.z;
      m2_a[6]  = dx;       m2_b[6]  = q_ff.x;
      m2_a[7]  = dy;       m2_b[7]  = q_ff.y;
      m2_a[8]  = dz;       m2_b[8]  = q_ff.z;
      m2_a[9]  = e2s.e2.x; m2_b[9]  = q_ff.x;
      m2_a[10] = e2s.e2.y; m2_b[10] = q_ff.y;
      m2_a[11] = e2s.e2.z; m2_b[11] = q_ff.z;
   end

   for (genvar g = 0; g < NMUL; g++) begin : g_mul
      rti_mul u_mul1 (
         .clock (clock),
         .adv   (adv),
         .a     (m1_a[g]),
         .b     (m1_b[g]),
         .p     (m1_p[g])
      );
      rti_mul u_mul2 (
         .clock (clock),
         .adv   (adv),
         .a     (m2_a[g]),
         .b     (m2_b[g]),
         .p     (m2_p[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         part_in[i] = DOT_W'(m2_p[3*i]) + DOT_W'(m2_p[3*i+1]);
         sum_in[i]  = part_ff[i] + DOT_W'(rest_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[GEOM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         edges_ff[0] <= edges_in;
         for (int k = 1; k < EDLY; k++) begin
            edges_ff[k] <= edges_ff[k-1];
         end
         p_ff <= p_in;
         q_ff <= q_in;
         for (int i = 0; i < 4; i++) begin
            part_ff[i] <= part_in[i];
            rest_ff[i] <= m2_p[3*i+2];
            sum_ff[i]  <= sum_in[i];
         end
      end
   end

   assign res.valid = v_ff[GEOM_LAT-1];
   assign res.det   = sum_ff[0];
   assign res.unum  = sum_ff[1];
   assign res.vnum  = sum_ff[2];
   assign res.tnum  = sum_ff[3];

endmodule

// ===== rtl/rti_test.sv =====
module rti_test (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  rti_pkg::geom_out_type din,
   output rti_pkg::test_out_type dout
);
   import rti_pkg::*;

   logic                  v17_ff, v18_ff, v19_ff, v20_ff, v21_ff;
   logic [DOT_W-1:0]      adet17_ff, adet17_in, adet18_ff, adet19_ff, adet20_ff, adet21_ff;
   dot_type               u17_ff, u17_in, vv17_ff, vv17_in, t17_ff, t17_in;
   dot_type               t18_ff, t19_ff;
   logic                  ok18_ff, ok18_in, vneg18_ff, ok19_ff, ok19_in, ok20_ff, ok20_in;
   logic [UV_W-1:0]       uv18_ff, uv18_in;
   logic [ADET_X_W-1:0]   adet_x;
   logic [EPS_PP_W-1:0]   epp_ff [ADET_LIMBS];
   logic [EPS_PP_W-1:0]   epp_in [ADET_LIMBS];
   logic [EPS_HALF_W-1:0] lo19_ff, lo19_in, hi19_ff, hi19_in;
   logic [RHS_W-1:0]      rhs20_ff, rhs20_in;
   logic [REM_W-1:0]      num20_ff, num20_in, num21_ff;
   logic                  sat20_ff, sat20_in, sat21_ff, hit21_ff, hit21_in;
   logic [CMP_W-1:0]      lhs20;
   dot_type               t20_ff;

   // sign correction: work with |det|
   assign adet17_in = din.det[DOT_W-1] ? -din.det : din.det;
   assign u17_in    = din.det[DOT_W-1] ? -din.unum : din.unum;
   assign vv17_in   = din.det[DOT_W-1] ? -din.vnum : din.vnum;
   assign t17_in    = din.det[DOT_W-1] ? -din.tnum : din.tnum;

   assign ok18_in = (adet17_ff >= DOT_W'(EPS_Q48)) && !u17_ff[DOT_W-1] &&
                    (adet17_ff >= DOT_W'(u17_ff));
   assign uv18_in = UV_W'(u17_ff) + UV_W'(vv17_ff);

   assign adet_x = ADET_X_W'(adet17_ff);
   always_comb begin
      for (int i = 0; i < ADET_LIMBS; i++) begin
         epp_in[i] = EPS_PP_W'(adet_x[i*ADET_LIMB_W +: ADET_LIMB_W]) * EPS_PP_W'(EPS_Q48);
      end
   end

   assign ok19_in = ok18_ff && !vneg18_ff && !uv18_ff[UV_W-1] &&
                    (UV_W'(adet18_ff) >= uv18_ff);
   assign lo19_in = EPS_HALF_W'(epp_ff[0]) + (EPS_HALF_W'(epp_ff[1]) << ADET_LIMB_W);
   assign hi19_in = EPS_HALF_W'(epp_ff[2]) + (EPS_HALF_W'(epp_ff[3]) << ADET_LIMB_W);

   // t*2^48 must exceed |det|*eps; saturate when t*2^16 >= |det|*2^31
   assign ok20_in  = ok19_ff && !t19_ff[DOT_W-1];
   assign rhs20_in = RHS_W'(lo19_ff) + (RHS_W'(hi19_ff) << (2 * ADET_LIMB_W));
   assign num20_in = REM_W'(t19_ff[DOT_W-2:0]) << NUM_SHIFT;
   assign sat20_in = num20_in >= (REM_W'(adet19_ff) << (DIST_W));

   assign lhs20    = CMP_W'(t20_ff[DOT_W-2:0]) << T_SHIFT;
   assign hit21_in = ok20_ff && (lhs20 > CMP_W'(rhs20_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v17_ff <= 1'b0;
         v18_ff <= 1'b0;
         v19_ff <= 1'b0;
         v20_ff <= 1'b0;
         v21_ff <= 1'b0;
      end else if (adv) begin
         v17_ff <= din.valid;
         v18_ff <= v17_ff;
         v19_ff <= v18_ff;
         v20_ff <= v19_ff;
         v21_ff <= v20_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         adet17_ff <= adet17_in;
         u17_ff    <= u17_in;
         vv17_ff   <= vv17_in;
         t17_ff    <= t17_in;
         ok18_ff   <= ok18_in;
         vneg18_ff <= vv17_ff[DOT_W-1];
         uv18_ff   <= uv18_in;
         adet18_ff <= adet17_ff;
         t18_ff    <= t17_ff;
         epp_ff    <= epp_in;
         ok19_ff   <= ok19_in;
         adet19_ff <= adet18_ff;
         t19_ff    <= t18_ff;
         lo19_ff   <= lo19_in;
         hi19_ff   <= hi19_in;
         ok20_ff   <= ok20_in;
         adet20_ff <= adet19_ff;
         t20_ff    <= t19_ff;
         rhs20_ff  <= rhs20_in;
         num20_ff  <= num20_in;
         sat20_ff  <= sat20_in;
         hit21_ff  <= hit21_in;
         adet21_ff <= adet20_ff;
         num21_ff  <= num20_ff;
         sat21_ff  <= sat20_ff;
      end
   end

   assign dout.valid = v21_ff;
   assign dout.hit   = hit21_ff;
   assign dout.sat   = sat21_ff;
   assign dout.adet  = adet21_ff;
   assign dout.num   = num21_ff;

endmodule

// ===== rtl/rti_div.sv =====
module rti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  rti_pkg::test_out_type din,
   output rti_pkg::div_out_type  dout
);
   import rti_pkg::*;

   // restoring divide, one quotient bit per stage, MSB first
   div_stage_type head;
   div_stage_type stg_ff [DIV_STEPS];
   div_stage_type last;

   always_comb begin
      head.valid = din.valid;
      head.hit   = din.hit;
      head.sat   = din.sat;
      head.adet  = din.adet;
      head.rem   = din.num;
      head.quo   = '0;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int SH = DIST_W - 1 - k;
      div_stage_type    src, nxt;
      logic [REM_W-1:0] step;

      if (k == 0) begin : g_first
         assign src = head;
      end else begin : g_next
         assign src = stg_ff[k-1];
      end

      always_comb begin
         nxt  = src;
         step = REM_W'(src.adet) << SH;
         if (src.rem >= step) begin
            nxt.rem     = src.rem - step;
            nxt.quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stg_ff[k] <= nxt;
         end
      end
   end

   assign last = stg_ff[DIV_STEPS-1];

   always_comb begin
      dout.valid   = last.valid;
      dout.res.hit = last.hit;
      if (!last.hit) begin
         dout.res.distance = '0;
      end else if (last.sat) begin
         dout.res.distance = DIST_MAX;
      end else begin
         dout.res.distance = last.quo;
      end
   end

endmodule

// ===== rtl/ray_triangle_intersect_unit.sv =====
// Ray/triangle intersection, one triangle per word against the configured ray.
// Throughput: one triangle per cycle while the skid word is empty; 24 pipelined
// 6-stage multipliers and a 31-stage restoring divider all advance together.
// Reset (synchronous): pipeline and output empty, origin 0, direction (0,0,1).
module ray_triangle_intersect_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first)
   input  logic [rti_pkg::REQ_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, distance (lowest first)
   output logic [rti_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rti_pkg::CSR_W-1:0]         csr_wdata
);
   import rti_pkg::*;

   ray_type      ray_ff;
   tri_type      triangle;
   geom_out_type geom_out;
   test_out_type test_out;
   div_out_type  div_out;
   logic         adv, push;
   logic         out_v_ff, skid_v_ff;
   res_type      out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff.origin.x <= '0;
         ray_ff.origin.y <= '0;
         ray_ff.origin.z <= '0;
         ray_ff.dir.x    <= '0;
         ray_ff.dir.y    <= '0;
         ray_ff.dir.z    <= DIR_Z_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X: ray_ff.origin.x <= csr_wdata;
            CSR_ORIGIN_Y: ray_ff.origin.y <= csr_wdata;
            CSR_ORIGIN_Z: ray_ff.origin.z <= csr_wdata;
            CSR_DIR_X:    ray_ff.dir.x    <= csr_wdata;
            CSR_DIR_Y:    ray_ff.dir.y    <= csr_wdata;
            CSR_DIR_Z:    ray_ff.dir.z    <= csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      triangle.a.x = req_tdata[0*COORD_W +: COORD_W];
      triangle.a.y = req_tdata[1*COORD_W +: COORD_W];
      triangle.a.z = req_tdata[2*COORD_W +: COORD_W];
      triangle.b.x = req_tdata[3*COORD_W +: COORD_W];
      triangle.b.y = req_tdata[4*COORD_W +: COORD_W];
      triangle.b.z = req_tdata[5*COORD_W +: COORD_W];
      triangle.c.x = req_tdata[6*COORD_W +: COORD_W];
      triangle.c.y = req_tdata[7*COORD_W +: COORD_W];
      triangle.c.z = req_tdata[8*COORD_W +: COORD_W];
   end

   // whole pipe advances unless the skid word is occupied
   assign adv        = !skid_v_ff;
   assign req_tready = adv;
   assign push       = div_out.valid && adv;

   rti_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid && adv),
      .triangle (triangle),
      .ray      (ray_ff),
      .res      (geom_out)
   );

   rti_test u_test (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .din   (geom_out),
      .dout  (test_out)
   );

   rti_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .din   (test_out),
      .dout  (div_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
            if (push) begin
               out_ff <= div_out.res;
            end
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
         skid_ff   <= div_out.res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.distance, out_ff.hit};

endmodule

// ===== rtl/rti_checker.sv =====
module rti_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [rti_pkg::RSP_W-1:0] rsp_tdata
);
   import rti_pkg::*;

   localparam int CNT_W = $clog2(UNIT_LAT + 2) + 1;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             acc_in, acc_out;

   assign acc_in  = req_tvalid && req_tready;
   assign acc_out = rsp_tvalid && rsp_tready;
   assign cnt_in  = cnt_ff + CNT_W'(acc_in) - CNT_W'(acc_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("miss with nonzero distance");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      acc_out |-> cnt_ff != '0)
      else $error("result without a pending triangle");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(UNIT_LAT + 1))
      else $error("more words in flight than the pipe holds");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (.*);
